### sv/luffa_hash_core_defines.svh
// Assertion macros for the Luffa hash core
`ifndef LUFFA_HASH_CORE_DEFINES_SVH
`define LUFFA_HASH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LHC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define LHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LHC_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define LHC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

### sv/luffa_pkg.sv
// Shared types, constant tables and helper functions of the Luffa hash core
package luffa_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] grp_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_INJECT = 4'b0010,
        S_STEP   = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        RK_BLOCK = 2'd0,
        RK_FINAL = 2'd1,
        RK_BLANK = 2'd2,
        RK_EXTRA = 2'd3
    } round_kind_t;

    localparam word_t LFSR_HI = 32'hc4d6496c;
    localparam word_t LFSR_LO = 32'h55c61c8d;
    localparam word_t PAD_BIT = 32'h80000000;

    localparam word_t ROUND_CONSTS [10] = '{
        32'h181cca53, 32'h380cde06, 32'h5b6f0876, 32'hf16f8594, 32'h7e106ce9,
        32'h38979cb0, 32'hbb62f364, 32'h92e93c29, 32'h9a025047, 32'hcff2a940
    };

    localparam word_t IV_TABLE [40] = '{
        32'h6d251e69, 32'h44b051e0, 32'h4eaa6fb4, 32'hdbf78465,
        32'h6e292011, 32'h90152df4, 32'hee058139, 32'hdef610bb,
        32'hc3b44b95, 32'hd9d2f256, 32'h70eee9a0, 32'hde099fa3,
        32'h5d9b0557, 32'h8fc944b3, 32'hcf1ccf0e, 32'h746cd581,
        32'hf7efc89d, 32'h5dba5781, 32'h04016ce5, 32'had659c05,
        32'h0306194f, 32'h666d1836, 32'h24aa230a, 32'h8b264ae7,
        32'h858075d5, 32'h36d79cce, 32'he571f7d7, 32'h204b1f67,
        32'h35870c6a, 32'h57e9e923, 32'h14bcb808, 32'h7cde72ce,
        32'h6c68e9be, 32'h5ec41e22, 32'hc825b7c7, 32'haffb4363,
        32'hf5df3999, 32'h0fc688f1, 32'hb07224cc, 32'h03e86cea
    };

    // rotate left by a constant amount
    function automatic word_t rotl(input word_t x, input int unsigned r);
        word_t res;
        if (r == 0) begin
            res = x;
        end else begin
            res = (x << r) | (x >> (32 - r));
        end
        return res;
    endfunction

    // multiply an 8-word group by two in the word ring
    function automatic grp_t times_two(input grp_t a);
        grp_t r;
        r[7] = a[6];
        r[6] = a[5];
        r[5] = a[4];
        r[4] = a[3] ^ a[7];
        r[3] = a[2] ^ a[7];
        r[2] = a[1];
        r[1] = a[0] ^ a[7];
        r[0] = a[7];
        return r;
    endfunction

endpackage

### sv/luffa_inject.sv
// Message injection and tweak over the active sub-states
module luffa_inject import luffa_pkg::*; #(
    parameter int MAX_SUBSTATES = 5,
    parameter int CW = $clog2(MAX_SUBSTATES + 1)
) (
    input  grp_t          chain_in  [MAX_SUBSTATES],
    input  grp_t          blk,
    input  logic [CW-1:0] sub_cnt,
    output grp_t          chain_out [MAX_SUBSTATES]
);

    grp_t cv [MAX_SUBSTATES];
    grp_t u  [MAX_SUBSTATES];
    grp_t t;
    grp_t m;
    grp_t ulast;

    always_comb begin
        // fold the sub-states, double, feed back
        t = '0;
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            cv[j] = chain_in[j];
            if (j < sub_cnt) t = t ^ chain_in[j];
        end
        t = times_two(t);
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            if (j < sub_cnt) cv[j] = cv[j] ^ t;
        end

        // mix with the following neighbor for five sub-states
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            u[j] = cv[j];
        end
        if (sub_cnt >= 5) begin
            for (int j = 0; j < MAX_SUBSTATES; j++) begin
                if (j < sub_cnt) begin
                    if (j + 1 < sub_cnt) begin
                        cv[j] = times_two(u[j]) ^ u[(j + 1) % MAX_SUBSTATES];
                    end else begin
                        cv[j] = times_two(u[j]) ^ u[0];
                    end
                end
            end
        end

        // mix with the preceding neighbor for four or more sub-states
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            u[j] = cv[j];
        end
        ulast = u[0];
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            if (j + 1 == sub_cnt) ulast = u[j];
        end
        if (sub_cnt >= 4) begin
            for (int j = 0; j < MAX_SUBSTATES; j++) begin
                if (j < sub_cnt) begin
                    if (j == 0) begin
                        cv[j] = times_two(u[j]) ^ ulast;
                    end else begin
                        cv[j] = times_two(u[j]) ^ u[(j + MAX_SUBSTATES - 1) % MAX_SUBSTATES];
                    end
                end
            end
        end

        // add the message block, doubled for each further sub-state
        m = blk;
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            if (j < sub_cnt) begin
                cv[j] = cv[j] ^ m;
                m = times_two(m);
            end
        end

        // tweak: rotate the upper half of sub-state j left by j
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            chain_out[j] = cv[j];
            if (j < sub_cnt) begin
                for (int i = 4; i < 8; i++) begin
                    chain_out[j][i] = rotl(cv[j][i], j);
                end
            end
        end
    end

endmodule

### sv/luffa_step.sv
// One Luffa step on one sub-state: SubCrumb, MixWord and constant addition
module luffa_step import luffa_pkg::*; (
    input  grp_t  grp_in,
    input  word_t c0_in,
    input  word_t c1_in,
    output grp_t  grp_out,
    output word_t c0_out,
    output word_t c1_out
);

    // four-word S-box layer
    function automatic logic [127:0] crumb(input word_t a0, input word_t a1,
                                           input word_t a2, input word_t a3);
        word_t x0, x1, x2, x3, t;
        t  = a0;
        x0 = a0; x1 = a1; x2 = a2; x3 = a3;
        x2 = x2 ^ x1;
        x0 = x0 & x1;
        x0 = x0 ^ x2;
        x1 = ~x1;
        x2 = x2 | t;
        x2 = x2 ^ x3;
        t  = t ^ x0;
        x3 = x3 & x0;
        x3 = x3 ^ x1;
        t  = ~t;
        x1 = x1 | x2;
        t  = t ^ x1;
        x0 = x0 ^ x3;
        x1 = x1 & x2;
        x1 = x1 ^ x3;
        x2 = x3;
        x3 = t;
        return {x3, x2, x1, x0};
    endfunction

    // word pair mixing
    function automatic logic [63:0] mix_pair(input word_t l, input word_t r);
        word_t x0, x4;
        x0 = l;
        x4 = r ^ x0;
        x0 = rotl(x0, 2) ^ x4;
        x4 = rotl(x4, 14) ^ x0;
        x0 = rotl(x0, 10) ^ x4;
        x4 = rotl(x4, 1);
        return {x4, x0};
    endfunction

    // constant generator: returns {new c1, new c0}; new c0 is the output
    function automatic logic [63:0] lfsr(input word_t hi, input word_t lo);
        word_t h, l;
        if (hi[31]) begin
            h = (hi << 1) ^ {31'd0, lo[31]} ^ LFSR_HI;
            l = (lo << 1) ^ LFSR_LO;
        end else begin
            h = (hi << 1) ^ {31'd0, lo[31]};
            l = lo << 1;
        end
        return {l, h};
    endfunction

    logic [127:0] crumb_lo, crumb_hi;
    logic [63:0]  mix0, mix1, mix2, mix3;
    logic [63:0]  gen0, gen1;

    assign crumb_lo = crumb(grp_in[0], grp_in[1], grp_in[2], grp_in[3]);
    assign crumb_hi = crumb(grp_in[4], grp_in[5], grp_in[6], grp_in[7]);

    assign mix0 = mix_pair(crumb_lo[31:0],   crumb_hi[31:0]);
    assign mix1 = mix_pair(crumb_lo[63:32],  crumb_hi[63:32]);
    assign mix2 = mix_pair(crumb_lo[95:64],  crumb_hi[95:64]);
    assign mix3 = mix_pair(crumb_lo[127:96], crumb_hi[127:96]);

    // two generator steps give the two step constants
    assign gen0 = lfsr(c0_in, c1_in);
    assign gen1 = lfsr(gen0[63:32], gen0[31:0]);

    assign grp_out[0] = mix0[31:0] ^ gen0[31:0];
    assign grp_out[1] = mix1[31:0];
    assign grp_out[2] = mix2[31:0];
    assign grp_out[3] = mix3[31:0];
    assign grp_out[4] = mix0[63:32] ^ gen1[31:0];
    assign grp_out[5] = mix1[63:32];
    assign grp_out[6] = mix2[63:32];
    assign grp_out[7] = mix3[63:32];

    assign c0_out = gen1[63:32];
    assign c1_out = gen1[31:0];

endmodule

### sv/luffa_hash_core.sv
// Luffa hash core top level: block buffer, round sequencer and digest output
// A non-final word is only written into the block buffer; a full block adds one round, in which
// the W active sub-states (W = 3, 3, 4, 5) pass in turn through the one shared step unit.
// The final word runs the padded round, a blank round if a full block came before,
// and for 384/512 one more round; digest words then leave one per cycle when taken.
// Reset (aresetn low, synchronous) loads the IV, clears the buffer and sets mode 256.
`include "luffa_hash_core_defines.svh"
module luffa_hash_core import luffa_pkg::*; #(
    parameter int MAX_SUBSTATES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_digest_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_msg_word,
    input  logic [5:0]  s_word_bits,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic        m_last_result
);

    localparam int CW = $clog2(MAX_SUBSTATES + 1);

    state_t      state_reg, state_next;
    round_kind_t kind_reg, kind_next;
    logic [1:0]  mode_reg, mode_next;
    grp_t        chain_reg [MAX_SUBSTATES];
    grp_t        chain_next [MAX_SUBSTATES];
    word_t       cst_reg [2*MAX_SUBSTATES];
    word_t       cst_next [2*MAX_SUBSTATES];
    grp_t        buf_reg, buf_next;
    logic [2:0]  wc_reg, wc_next;
    logic        long_reg, long_next;
    logic        pad_reg, pad_next;
    logic        partb_reg, partb_next;
    logic [CW-1:0] sub_reg, sub_next;
    logic [2:0]  step_reg, step_next;
    logic [2:0]  idx_reg, idx_next;
    logic        mv_reg, mv_next;
    word_t       mw_reg, mw_next;
    logic        ml_reg, ml_next;

    logic [CW-1:0] w;
    grp_t        inj_out [MAX_SUBSTATES];
    grp_t        step_grp;
    word_t       step_c0, step_c1;
    word_t       fold_word;
    word_t       keep_mask, pad_word;
    logic        full_word, out_last, part_end;
    int          w_int;

    // active sub-state count from the mode
    always_comb begin
        case (mode_reg)
            2'd3:    w_int = 5;
            2'd2:    w_int = 4;
            default: w_int = 3;
        endcase
        if (w_int > MAX_SUBSTATES) w_int = MAX_SUBSTATES;
    end
    assign w = CW'(w_int);

    luffa_inject #(.MAX_SUBSTATES(MAX_SUBSTATES), .CW(CW)) u_inject (
        .chain_in  (chain_reg),
        .blk       (buf_reg),
        .sub_cnt   (w),
        .chain_out (inj_out)
    );

    luffa_step u_step (
        .grp_in  (chain_reg[0]),
        .c0_in   (cst_reg[0]),
        .c1_in   (cst_reg[1]),
        .grp_out (step_grp),
        .c0_out  (step_c0),
        .c1_out  (step_c1)
    );

    // digest word: XOR of the active sub-states
    always_comb begin
        fold_word = '0;
        for (int j = 0; j < MAX_SUBSTATES; j++) begin
            if (j < w) fold_word = fold_word ^ chain_reg[j][idx_reg];
        end
    end

    assign full_word = !s_last_word || (s_word_bits >= 6'd32);
    assign keep_mask = ~(32'hffffffff >> s_word_bits);
    assign pad_word  = PAD_BIT >> s_word_bits;
    assign part_end  = partb_reg ? (idx_reg == ((mode_reg == 2'd3) ? 3'd7 : 3'd3))
                                 : (idx_reg == ((mode_reg == 2'd0) ? 3'd6 : 3'd7));
    assign out_last  = part_end && (partb_reg || mode_reg < 2'd2);

    // take config and items only when idle; a config write wins over an item
    assign s_ready       = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_valid       = mv_reg;
    assign m_digest_word = mw_reg;
    assign m_last_result = ml_reg;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        mode_next  = mode_reg;
        chain_next = chain_reg;
        cst_next   = cst_reg;
        buf_next   = buf_reg;
        wc_next    = wc_reg;
        long_next  = long_reg;
        pad_next   = pad_reg;
        partb_next = partb_reg;
        sub_next   = sub_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        mv_next    = mv_reg;
        mw_next    = mw_reg;
        ml_next    = ml_reg;

        // drop the output item once taken
        if (mv_reg && m_ready) mv_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    // new mode aborts the message and reloads the IV
                    mode_next = cfg_digest_mode;
                    for (int j = 0; j < MAX_SUBSTATES; j++) begin
                        for (int i = 0; i < 8; i++) chain_next[j][i] = IV_TABLE[8*j + i];
                    end
                    buf_next  = '0;
                    wc_next   = '0;
                    long_next = 1'b0;
                end else if (s_valid) begin
                    if (full_word) begin
                        buf_next[wc_reg] = s_msg_word;
                        wc_next = wc_reg + 3'd1;
                        if (wc_reg == 3'd7) begin
                            pad_next   = s_last_word;
                            kind_next  = RK_BLOCK;
                            state_next = S_INJECT;
                        end else if (s_last_word) begin
                            buf_next[wc_reg + 3'd1] = PAD_BIT;
                            kind_next  = RK_FINAL;
                            state_next = S_INJECT;
                        end
                    end else begin
                        buf_next[wc_reg] = (s_msg_word & keep_mask) | pad_word;
                        kind_next  = RK_FINAL;
                        state_next = S_INJECT;
                    end
                end
            end

            S_INJECT: begin
                chain_next = inj_out;
                for (int k = 0; k < 2*MAX_SUBSTATES; k++) cst_next[k] = ROUND_CONSTS[k];
                sub_next   = '0;
                step_next  = '0;
                state_next = S_STEP;
            end

            S_STEP: begin
                // rotate the sub-states through the shared step unit
                for (int k = 0; k < MAX_SUBSTATES; k++) begin
                    if (k + 1 < w) begin
                        chain_next[k]     = chain_reg[(k + 1) % MAX_SUBSTATES];
                        cst_next[2*k]     = cst_reg[(2*k + 2) % (2*MAX_SUBSTATES)];
                        cst_next[2*k + 1] = cst_reg[(2*k + 3) % (2*MAX_SUBSTATES)];
                    end else if (k + 1 == w) begin
                        chain_next[k]     = step_grp;
                        cst_next[2*k]     = step_c0;
                        cst_next[2*k + 1] = step_c1;
                    end
                end
                if (sub_reg == w - CW'(1)) begin
                    sub_next  = '0;
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd7) begin
                        // round done: clear the buffer and pick what follows
                        buf_next = '0;
                        case (kind_reg)
                            RK_BLOCK: begin
                                long_next = 1'b1;
                                if (pad_reg) begin
                                    buf_next[0] = PAD_BIT;
                                    kind_next   = RK_FINAL;
                                    state_next  = S_INJECT;
                                end else begin
                                    state_next  = S_IDLE;
                                end
                            end
                            RK_FINAL: begin
                                if (long_reg) begin
                                    kind_next  = RK_BLANK;
                                    state_next = S_INJECT;
                                end else begin
                                    partb_next = 1'b0;
                                    idx_next   = '0;
                                    state_next = S_OUT;
                                end
                            end
                            RK_BLANK: begin
                                partb_next = 1'b0;
                                idx_next   = '0;
                                state_next = S_OUT;
                            end
                            RK_EXTRA: begin
                                idx_next   = '0;
                                state_next = S_OUT;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end else begin
                    sub_next = sub_reg + CW'(1);
                end
            end

            S_OUT: begin
                // load the next digest word when the output register is free
                if (!mv_reg || m_ready) begin
                    mv_next  = 1'b1;
                    mw_next  = fold_word;
                    ml_next  = out_last;
                    idx_next = idx_reg + 3'd1;
                    if (part_end) begin
                        idx_next = '0;
                        if (!partb_reg && mode_reg >= 2'd2) begin
                            partb_next = 1'b1;
                            kind_next  = RK_EXTRA;
                            state_next = S_INJECT;
                        end else begin
                            for (int j = 0; j < MAX_SUBSTATES; j++) begin
                                for (int i = 0; i < 8; i++) begin
                                    chain_next[j][i] = IV_TABLE[8*j + i];
                                end
                            end
                            buf_next   = '0;
                            wc_next    = '0;
                            long_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= RK_BLOCK;
            mode_reg  <= 2'd1;
            for (int j = 0; j < MAX_SUBSTATES; j++) begin
                for (int i = 0; i < 8; i++) chain_reg[j][i] <= IV_TABLE[8*j + i];
            end
            for (int k = 0; k < 2*MAX_SUBSTATES; k++) cst_reg[k] <= '0;
            buf_reg   <= '0;
            wc_reg    <= '0;
            long_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            partb_reg <= 1'b0;
            sub_reg   <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
            mv_reg    <= 1'b0;
            ml_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            mode_reg  <= mode_next;
            chain_reg <= chain_next;
            cst_reg   <= cst_next;
            buf_reg   <= buf_next;
            wc_reg    <= wc_next;
            long_reg  <= long_next;
            pad_reg   <= pad_next;
            partb_reg <= partb_next;
            sub_reg   <= sub_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            mv_reg    <= mv_next;
            ml_reg    <= ml_next;
        end
    end

    always_ff @(posedge aclk) begin
        mw_reg <= mw_next;
    end

    `LHC_ASSERT_IMP(a_sub_in_range, aclk, aresetn, state_reg == S_STEP, sub_reg < w, "sub-state counter out of range")
    `LHC_ASSERT_NEXT(a_inject_to_step, aclk, aresetn, state_reg == S_INJECT, state_reg == S_STEP, "injection not followed by steps")
    `LHC_ASSERT_NEXT(a_msg_cleared, aclk, aresetn, state_reg == S_OUT && state_next == S_IDLE, wc_reg == 3'd0 && !long_reg, "message state not cleared after digest")

endmodule
